FILE: hdl/gaussian_bayes_class_stats_unit_defines.svh
// Assertion macros shared by the class statistics unit.
`ifndef GAUSSIAN_BAYES_CLASS_STATS_UNIT_DEFINES_SVH
`define GAUSSIAN_BAYES_CLASS_STATS_UNIT_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define GBCS_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("gbcs assertion failed");

// antecedent implies consequent in the next cycle
`define GBCS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("gbcs assertion failed");

`endif

FILE: hdl/gbcs_pkg.sv
// Shared types and constants of the class statistics unit.
package gbcs_pkg;

    localparam int NUM_FEAT    = 16;
    localparam int NUM_CLS     = 8;
    localparam int FEAT_W      = 4;
    localparam int CLS_W       = 3;
    localparam int ENTRIES     = NUM_FEAT * NUM_CLS;
    localparam int IDX_W       = $clog2(ENTRIES);
    localparam int VAL_W       = 24;
    localparam int CNT_W       = 16;
    localparam int SUM_W       = 40;
    localparam int SQ_W        = 64;
    localparam int PROD_W      = 80;
    localparam int VAR_W       = 47;
    localparam int PRES_W      = 4;
    localparam int STAT_W      = 3;
    localparam int MUL_LEN     = 40;
    localparam int DIV_LEN     = 64;
    localparam int STEP_W      = 6;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 96;

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;
    localparam logic [VAR_W-1:0] VAR_MAX   = '1;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_ADD   = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK       = 3'd0,
        STAT_EMPTY    = 3'd1,
        STAT_ONE      = 3'd2,
        STAT_ZERO_VAR = 3'd3,
        STAT_SAT      = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD,
        ST_MUL_A,
        ST_MUL_B,
        ST_DIFF,
        ST_DIV_VAR,
        ST_DIV_MEAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic              accept;
        logic              clear;
        logic              add_wr;
        logic              mul_step;
        logic              mul_first;
        logic              mul_sel_b;
        logic              save_a;
        logic              diff;
        logic              div_step;
        logic              div_first;
        logic              div_sel_mean;
        logic              save_var;
        logic              out_load;
        logic [STEP_W-1:0] step_idx;
    } ctl_t;

    typedef struct packed {
        logic out_busy;
    } stat_t;

endpackage

FILE: hdl/gaussian_bayes_class_stats_unit.sv
// Top level of the Gaussian naive Bayes class statistics unit.
// Keeps count, sum and sum of squares per feature and class in a 128-word
// store. A clear or unused command is done on accept; an add reads the entry,
// then writes it back. A read runs through the accept, two 40-step shift-add
// multiplications for n*sumsq and sum^2, a difference step, then two 64-step
// runs of one restoring divider (variance, then mean), and the load of the
// result register. That load is held while an earlier result has not been
// taken. The next word is accepted while the result still waits to be taken.
module gaussian_bayes_class_stats_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // cmd[1:0], feature_index[5:2], class_label[8:6], value[32:9]
    input  logic [gbcs_pkg::IN_TDATA_W-1:0]     s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // mean[23:0], variance[70:24], sample_total[86:71],
    // classes_present[90:87], status[93:91]
    output logic [gbcs_pkg::OUT_TDATA_W-1:0]    m_tdata
);

    gbcs_pkg::ctl_t  ctl;
    gbcs_pkg::stat_t stat;
    gbcs_pkg::cmd_t  cmd;
    logic signed [gbcs_pkg::VAL_W-1:0] mean;
    logic [gbcs_pkg::VAR_W-1:0]  variance;
    logic [gbcs_pkg::CNT_W-1:0]  sample_total;
    logic [gbcs_pkg::PRES_W-1:0] classes_present;
    logic [gbcs_pkg::STAT_W-1:0] status;

    assign cmd = gbcs_pkg::cmd_t'(s_tdata[1:0]);

    gbcs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .stat     (stat),
        .ctl      (ctl)
    );

    gbcs_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .ctl             (ctl),
        .stat            (stat),
        .feature_index   (s_tdata[5:2]),
        .class_label     (s_tdata[8:6]),
        .value           (s_tdata[32:9]),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .mean            (mean),
        .variance        (variance),
        .sample_total    (sample_total),
        .classes_present (classes_present),
        .status          (status)
    );

    assign m_tdata = {2'b00, status, classes_present, sample_total, variance, mean};

endmodule

FILE: hdl/gbcs_ctrl.sv
// Sequencer for add, clear and read commands of the class statistics unit.
`include "gaussian_bayes_class_stats_unit_defines.svh"

module gbcs_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  gbcs_pkg::cmd_t  cmd,
    input  gbcs_pkg::stat_t stat,
    output gbcs_pkg::ctl_t  ctl
);

    gbcs_pkg::state_t state_reg, state_next;
    logic [gbcs_pkg::STEP_W-1:0] cnt_reg, cnt_next;
    logic accept;

    assign accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= gbcs_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            gbcs_pkg::ST_IDLE: begin
                cnt_next = '0;
                if (accept) begin
                    if (cmd == gbcs_pkg::CMD_ADD) state_next = gbcs_pkg::ST_ADD;
                    else if (cmd == gbcs_pkg::CMD_READ) state_next = gbcs_pkg::ST_MUL_A;
                end
            end
            gbcs_pkg::ST_ADD: state_next = gbcs_pkg::ST_IDLE;
            gbcs_pkg::ST_MUL_A, gbcs_pkg::ST_MUL_B: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == gbcs_pkg::STEP_W'(gbcs_pkg::MUL_LEN - 1)) begin
                    cnt_next   = '0;
                    state_next = (state_reg == gbcs_pkg::ST_MUL_A) ?
                                 gbcs_pkg::ST_MUL_B : gbcs_pkg::ST_DIFF;
                end
            end
            gbcs_pkg::ST_DIFF: begin
                cnt_next   = '0;
                state_next = gbcs_pkg::ST_DIV_VAR;
            end
            gbcs_pkg::ST_DIV_VAR, gbcs_pkg::ST_DIV_MEAN: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == gbcs_pkg::STEP_W'(gbcs_pkg::DIV_LEN - 1)) begin
                    cnt_next   = '0;
                    state_next = (state_reg == gbcs_pkg::ST_DIV_VAR) ?
                                 gbcs_pkg::ST_DIV_MEAN : gbcs_pkg::ST_DONE;
                end
            end
            gbcs_pkg::ST_DONE: begin
                if (!stat.out_busy) state_next = gbcs_pkg::ST_IDLE;
            end
            default: state_next = gbcs_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        ctl          = '0;
        ctl.step_idx = cnt_reg;
        s_tready     = 1'b0;
        unique case (state_reg)
            gbcs_pkg::ST_IDLE: begin
                s_tready   = 1'b1;
                ctl.accept = accept;
                ctl.clear  = accept && (cmd == gbcs_pkg::CMD_CLEAR);
            end
            gbcs_pkg::ST_ADD: ctl.add_wr = 1'b1;
            gbcs_pkg::ST_MUL_A: begin
                ctl.mul_step  = 1'b1;
                ctl.mul_first = (cnt_reg == '0);
            end
            gbcs_pkg::ST_MUL_B: begin
                ctl.mul_step  = 1'b1;
                ctl.mul_sel_b = 1'b1;
                ctl.mul_first = (cnt_reg == '0);
                ctl.save_a    = (cnt_reg == '0);
            end
            gbcs_pkg::ST_DIFF: ctl.diff = 1'b1;
            gbcs_pkg::ST_DIV_VAR: begin
                ctl.div_step  = 1'b1;
                ctl.div_first = (cnt_reg == '0);
            end
            gbcs_pkg::ST_DIV_MEAN: begin
                ctl.div_step     = 1'b1;
                ctl.div_sel_mean = 1'b1;
                ctl.div_first    = (cnt_reg == '0);
                ctl.save_var     = (cnt_reg == '0);
            end
            gbcs_pkg::ST_DONE: ctl.out_load = !stat.out_busy;
            default: ;
        endcase
    end

    `GBCS_ASSERT_NEXT(a_add_seq, aclk, aresetn,
        accept && cmd == gbcs_pkg::CMD_ADD, state_reg == gbcs_pkg::ST_ADD)
    `GBCS_ASSERT_SAME(a_load_free, aclk, aresetn, ctl.out_load, !stat.out_busy)
    `GBCS_ASSERT_SAME(a_mul_cnt, aclk, aresetn, ctl.mul_step,
        cnt_reg < gbcs_pkg::STEP_W'(gbcs_pkg::MUL_LEN))

endmodule

FILE: hdl/gbcs_datapath.sv
// Statistics store, shift-add multiplier, restoring divider and result register.
module gbcs_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  gbcs_pkg::ctl_t                      ctl,
    output gbcs_pkg::stat_t                     stat,
    input  logic [gbcs_pkg::FEAT_W-1:0]         feature_index,
    input  logic [gbcs_pkg::CLS_W-1:0]          class_label,
    input  logic signed [gbcs_pkg::VAL_W-1:0]   value,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic signed [gbcs_pkg::VAL_W-1:0]   mean,
    output logic [gbcs_pkg::VAR_W-1:0]          variance,
    output logic [gbcs_pkg::CNT_W-1:0]          sample_total,
    output logic [gbcs_pkg::PRES_W-1:0]         classes_present,
    output logic [gbcs_pkg::STAT_W-1:0]         status
);

    localparam int WORD_W = gbcs_pkg::CNT_W + gbcs_pkg::SUM_W + gbcs_pkg::SQ_W;

    logic [WORD_W-1:0] mem [gbcs_pkg::ENTRIES];
    logic [WORD_W-1:0] rd_reg;
    logic [gbcs_pkg::ENTRIES-1:0] valid_reg;

    logic [gbcs_pkg::FEAT_W-1:0] feat_reg;
    logic signed [gbcs_pkg::VAL_W-1:0] val_reg;
    logic [2*gbcs_pkg::VAL_W-1:0] vsq_reg;
    logic inrange_reg;

    logic [gbcs_pkg::IDX_W-1:0] idx_in, idx_reg;
    logic hit;
    logic [gbcs_pkg::CNT_W-1:0] cur_cnt, n;
    logic signed [gbcs_pkg::SUM_W-1:0] cur_sum;
    logic [gbcs_pkg::SQ_W-1:0] cur_sq;
    logic sum_neg;
    logic [gbcs_pkg::SUM_W-1:0] sum_mag;

    logic [gbcs_pkg::PROD_W-1:0] acc_reg, a_reg, diff_reg, acc_base, mcand;
    logic [gbcs_pkg::MUL_LEN-1:0] mplier;
    logic zero_reg;
    logic [31:0] d_reg, divisor, rem_reg, rem_in, rem_next;
    logic [63:0] q_reg, q_in;
    logic [32:0] rem_sh;
    logic ge, over;
    logic [gbcs_pkg::VAR_W-1:0] var_reg;

    logic [gbcs_pkg::NUM_CLS-1:0] row;
    logic [gbcs_pkg::PRES_W-1:0] present;
    logic run;
    logic [gbcs_pkg::VAL_W-1:0] mean_q;
    gbcs_pkg::status_t st;
    logic m_tvalid_reg;

    assign idx_in = gbcs_pkg::IDX_W'(feature_index * gbcs_pkg::NUM_CLS + class_label);

    always_ff @(posedge aclk) begin
        if (ctl.accept) begin
            rd_reg      <= mem[idx_in];
            idx_reg     <= idx_in;
            feat_reg    <= feature_index;
            val_reg     <= value;
            vsq_reg     <= (2*gbcs_pkg::VAL_W)'(value * value);
            inrange_reg <= (int'(feature_index) < gbcs_pkg::NUM_FEAT) &&
                           (int'(class_label) < gbcs_pkg::NUM_CLS);
        end
    end

    assign hit     = inrange_reg && valid_reg[idx_reg];
    assign cur_cnt = hit ? rd_reg[WORD_W-1 -: gbcs_pkg::CNT_W] : '0;
    assign cur_sum = hit ? rd_reg[gbcs_pkg::SQ_W +: gbcs_pkg::SUM_W] : '0;
    assign cur_sq  = hit ? rd_reg[gbcs_pkg::SQ_W-1:0] : '0;
    assign n       = cur_cnt;
    assign sum_neg = cur_sum[gbcs_pkg::SUM_W-1];
    assign sum_mag = sum_neg ? gbcs_pkg::SUM_W'(-cur_sum) : cur_sum;

    always_ff @(posedge aclk) begin
        if (ctl.add_wr && inrange_reg && cur_cnt != gbcs_pkg::COUNT_MAX) begin
            mem[idx_reg] <= {cur_cnt + 1'b1,
                             cur_sum + gbcs_pkg::SUM_W'(val_reg),
                             cur_sq + gbcs_pkg::SQ_W'(vsq_reg)};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || ctl.clear) begin
            valid_reg <= '0;
        end else if (ctl.add_wr && inrange_reg) begin
            valid_reg[idx_reg] <= 1'b1;
        end
    end

    assign mplier   = ctl.mul_sel_b ? sum_mag : gbcs_pkg::MUL_LEN'(n);
    assign mcand    = ctl.mul_sel_b ? gbcs_pkg::PROD_W'(sum_mag) : gbcs_pkg::PROD_W'(cur_sq);
    assign acc_base = ctl.mul_first ? '0 : acc_reg;

    always_ff @(posedge aclk) begin
        if (ctl.mul_step) begin
            acc_reg <= {acc_base[gbcs_pkg::PROD_W-2:0], 1'b0} +
                       (mplier[gbcs_pkg::STEP_W'(gbcs_pkg::MUL_LEN - 1) - ctl.step_idx] ?
                        mcand : '0);
        end
        if (ctl.save_a) a_reg <= acc_reg;
        if (ctl.diff) begin
            zero_reg <= a_reg <= acc_reg;
            diff_reg <= a_reg - acc_reg;
            d_reg    <= 32'(n) * 32'(n - 1'b1);
        end
    end

    assign divisor = ctl.div_sel_mean ? 32'(n) : d_reg;
    assign rem_in  = ctl.div_first ?
                     (ctl.div_sel_mean ? '0 : 32'(diff_reg[gbcs_pkg::PROD_W-1:64])) : rem_reg;
    assign q_in    = ctl.div_first ?
                     (ctl.div_sel_mean ? 64'(sum_mag) : diff_reg[63:0]) : q_reg;
    assign rem_sh  = {rem_in, q_in[63]};
    assign ge      = rem_sh >= {1'b0, divisor};
    assign rem_next = ge ? 32'(rem_sh - {1'b0, divisor}) : rem_sh[31:0];
    assign over    = 32'(diff_reg[gbcs_pkg::PROD_W-1:64]) >= d_reg;

    always_ff @(posedge aclk) begin
        if (ctl.div_step) begin
            rem_reg <= rem_next;
            q_reg   <= {q_in[62:0], ge};
        end
        if (ctl.save_var) begin
            var_reg <= (over || q_reg > 64'(gbcs_pkg::VAR_MAX)) ?
                       gbcs_pkg::VAR_MAX : q_reg[gbcs_pkg::VAR_W-1:0];
        end
    end

    assign row = valid_reg[feat_reg * gbcs_pkg::NUM_CLS +: gbcs_pkg::NUM_CLS];

    always_comb begin
        present = '0;
        run     = 1'b1;
        for (int c = 0; c < gbcs_pkg::NUM_CLS; c++) begin
            run = run && row[c];
            if (run) present = present + 1'b1;
        end
        if (!(int'(feat_reg) < gbcs_pkg::NUM_FEAT)) present = '0;
    end

    assign mean_q = q_reg[gbcs_pkg::VAL_W-1:0];

    always_comb begin
        if (n == '0) st = gbcs_pkg::STAT_EMPTY;
        else if (n == 16'd1) st = gbcs_pkg::STAT_ONE;
        else if (n == gbcs_pkg::COUNT_MAX) st = gbcs_pkg::STAT_SAT;
        else if (zero_reg) st = gbcs_pkg::STAT_ZERO_VAR;
        else st = gbcs_pkg::STAT_OK;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (ctl.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.out_load) begin
            mean            <= (n == '0) ? '0 : (sum_neg ? -mean_q : mean_q);
            variance        <= (n < 16'd2 || zero_reg) ? '0 : var_reg;
            sample_total    <= n;
            classes_present <= present;
            status          <= st;
        end
    end

    assign m_tvalid      = m_tvalid_reg;
    assign stat.out_busy = m_tvalid_reg && !m_tready;

endmodule

FILE: tb/sv/gaussian_bayes_class_stats_unit_test.sv
// Self-checking testbench for the Gaussian naive Bayes class statistics unit.
module gaussian_bayes_class_stats_unit_test;
    import gbcs_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int DRAIN_WAIT  = 250;

    typedef struct {
        logic [VAL_W-1:0]  mean;
        logic [VAR_W-1:0]  variance;
        logic [CNT_W-1:0]  total;
        logic [PRES_W-1:0] present;
        status_t           status;
    } class_stats_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    bit                 entry_used[ENTRIES];
    logic [CNT_W-1:0]   entry_count[ENTRIES];
    longint             entry_sum[ENTRIES];
    logic [SQ_W-1:0]    entry_sqsum[ENTRIES];
    class_stats_t       pending_stats[$];
    int                 mismatches = 0;
    int                 cycles = 0;
    bit                 calm = 1'b0;

    gaussian_bayes_class_stats_unit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic bit idle_now();
        return !calm && ($urandom_range(99) < 32);
    endfunction

    function automatic logic [VAR_W-1:0] variance_of(int unsigned n, longint s,
                                                     logic [SQ_W-1:0] sq,
                                                     output bit zero);
        logic [127:0] lhs;
        logic [127:0] rhs;
        logic [127:0] den;
        logic [127:0] quot;
        logic [63:0]  mag;
        mag = (s < 0) ? -s : s;
        lhs = n;
        lhs = lhs * sq;
        rhs = mag;
        rhs = rhs * mag;
        zero = (lhs <= rhs);
        if (zero)
            return '0;
        den = n;
        den = den * (n - 1);
        quot = (lhs - rhs) / den;
        return (quot > VAR_MAX) ? VAR_MAX : quot[VAR_W-1:0];
    endfunction

    task automatic apply_word(cmd_t cmd, int f, int c, logic [VAL_W-1:0] v);
        int           idx;
        int           n;
        longint       sv;
        bit           zero;
        class_stats_t r;
        idx = f * NUM_CLS + c;
        sv = longint'($signed(v));
        case (cmd)
            CMD_CLEAR: begin
                foreach (entry_used[i]) entry_used[i] = 1'b0;
            end
            CMD_ADD: begin
                if (!entry_used[idx]) begin
                    entry_used[idx] = 1'b1;
                    entry_count[idx] = '0;
                    entry_sum[idx] = 0;
                    entry_sqsum[idx] = '0;
                end
                if (entry_count[idx] != COUNT_MAX) begin
                    entry_count[idx] = entry_count[idx] + 1'b1;
                    entry_sum[idx] = entry_sum[idx] + sv;
                    entry_sqsum[idx] = entry_sqsum[idx] + 64'(sv * sv);
                end
            end
            CMD_READ: begin
                n = entry_used[idx] ? entry_count[idx] : 0;
                r.mean = '0;
                r.variance = '0;
                r.total = CNT_W'(n);
                r.present = '0;
                for (int k = 0; k < NUM_CLS; k++) begin
                    if (!entry_used[f * NUM_CLS + k] || entry_count[f * NUM_CLS + k] == 0)
                        break;
                    r.present = r.present + 1'b1;
                end
                if (n == 0) begin
                    r.status = STAT_EMPTY;
                end else begin
                    r.mean = VAL_W'(entry_sum[idx] / longint'(n));
                    if (n == 1) begin
                        r.status = STAT_ONE;
                    end else begin
                        r.variance = variance_of(n, entry_sum[idx], entry_sqsum[idx], zero);
                        if (n >= COUNT_MAX)
                            r.status = STAT_SAT;
                        else if (zero)
                            r.status = STAT_ZERO_VAR;
                        else
                            r.status = STAT_OK;
                    end
                end
                pending_stats.push_back(r);
            end
            default: ;
        endcase
    endtask

    task automatic send_word(cmd_t cmd, int f, int c, logic [VAL_W-1:0] v);
        @(negedge aclk);
        while (idle_now()) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata = {7'b0, v, c[CLS_W-1:0], f[FEAT_W-1:0], cmd};
        do @(posedge aclk); while (!s_tready);
        apply_word(cmd, f, c, v);
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_stats.size() != 0) @(posedge aclk);
    endtask

    task automatic report(string what, logic [127:0] got, logic [127:0] want);
        mismatches++;
        $display("mismatch %s: got %0h want %0h", what, got, want);
    endtask

    always @(negedge aclk) begin
        m_tready <= !idle_now();
    end

    always @(posedge aclk) begin
        class_stats_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_stats.size() == 0) begin
                report("unexpected word", m_tdata, 0);
            end else begin
                want = pending_stats.pop_front();
                if (m_tdata[23:0] !== want.mean)
                    report("mean", m_tdata[23:0], want.mean);
                if (m_tdata[70:24] !== want.variance)
                    report("variance", m_tdata[70:24], want.variance);
                if (m_tdata[86:71] !== want.total)
                    report("sample_total", m_tdata[86:71], want.total);
                if (m_tdata[90:87] !== want.present)
                    report("classes_present", m_tdata[90:87], want.present);
                if (m_tdata[93:91] !== want.status)
                    report("status", m_tdata[93:91], want.status);
            end
        end
    end

    task automatic test_empty_reads();
        send_word(CMD_READ, 0, 0, '0);
        send_word(CMD_READ, NUM_FEAT - 1, NUM_CLS - 1, 24'hFFFFFF);
    endtask

    task automatic test_extremes();
        send_word(CMD_ADD, 0, 0, 24'h800000);
        send_word(CMD_READ, 0, 0, '0);
        send_word(CMD_ADD, 0, 0, 24'h7FFFFF);
        send_word(CMD_READ, 0, 0, '0);
        send_word(CMD_ADD, 0, 1, 24'hFFFFFF);
        send_word(CMD_ADD, 0, 1, 24'h000001);
        send_word(CMD_ADD, 0, 1, 24'hFFFFFE);
        send_word(CMD_READ, 0, 1, '0);
        send_word(CMD_ADD, NUM_FEAT - 1, NUM_CLS - 1, 24'h7FFFFF);
        send_word(CMD_ADD, NUM_FEAT - 1, NUM_CLS - 1, 24'h800000);
        send_word(CMD_READ, NUM_FEAT - 1, NUM_CLS - 1, '0);
    endtask

    task automatic test_zero_variance();
        repeat (3) send_word(CMD_ADD, 0, 2, 24'h123456);
        send_word(CMD_READ, 0, 2, '0);
        send_word(CMD_READ, 0, 5, '0);
    endtask

    task automatic test_clear_and_unused();
        send_word(CMD_NONE, 0, 0, 24'hABCDEF);
        send_word(CMD_READ, 0, 0, '0);
        send_word(CMD_CLEAR, 0, 0, '0);
        send_word(CMD_READ, 0, 0, '0);
        send_word(CMD_ADD, 0, 0, 24'h000100);
        send_word(CMD_READ, 0, 0, '0);
    endtask

    task automatic test_random(int items);
        int               pick;
        cmd_t             cmd;
        logic [VAL_W-1:0] v;
        for (int i = 0; i < items; i++) begin
            calm = (i >= items / 3 && i < items / 3 + 150);
            if (i == items / 2)
                wait_drained();
            pick = $urandom_range(99);
            if (pick < 56)
                cmd = CMD_ADD;
            else if (pick < 95)
                cmd = CMD_READ;
            else if (pick < 98)
                cmd = CMD_CLEAR;
            else
                cmd = CMD_NONE;
            case ($urandom_range(3))
                0: v = VAL_W'($urandom);
                1: v = VAL_W'($urandom_range(255));
                2: v = VAL_W'(-$urandom_range(4096));
                default: v = 24'h002000;
            endcase
            send_word(cmd, $urandom_range(3) == 0 ? $urandom_range(NUM_FEAT - 1)
                                                  : $urandom_range(1),
                      $urandom_range(NUM_CLS - 1), v);
        end
        calm = 1'b0;
    endtask

    initial begin
        foreach (entry_used[i]) entry_used[i] = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_empty_reads();
        test_extremes();
        test_zero_variance();
        test_clear_and_unused();
        test_random(1100);
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (mismatches == 0 && pending_stats.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
